FILE: design/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg: shared constants and a table for the sRGB to L*a*b* pixel unit
// Q24 fixed-point widths, pipeline latencies and the sRGB linearization table.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int QB          = 24;
  localparam int LinW        = QB + 1;
  localparam int FracBitsDef = 8;
  localparam int XyzNumW     = 41;
  localparam int WhiteYDiv   = 10000;
  localparam int DivLat      = 4;
  localparam int CbrtSteps   = QB + 1;
  localparam int LabLat      = CbrtSteps + 1;

  typedef logic [LinW-1:0] lin_tab_t [256];

  function automatic logic [LinW-1:0] lin_entry(input int unsigned c);
    logic [63:0] v;
    logic [63:0] v2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] s2;
    logic [63:0] s4;
    logic [63:0] p;
    logic [LinW-1:0] res;
    int n;
    if (64'(c) * 100000 > 1031475) begin
      v  = ((64'(c) * 1000 + 14025) << QB) / 269025;
      v2 = (v * v) >> QB;
      lo = '0;
      hi = 64'd1 << QB;
      for (n = 0; n < QB + 2; n++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo + 1) >> 1);
          s2  = (mid * mid) >> QB;
          s4  = (s2 * s2) >> QB;
          p   = (s4 * mid) >> QB;
          if (p <= v2) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
      end
      res = LinW'((v2 * lo) >> QB);
    end else begin
      res = LinW'(((64'(c) * 100) << QB) / 329460);
    end
    return res;
  endfunction

  function automatic lin_tab_t lin_table();
    lin_tab_t tab;
    int c;
    for (c = 0; c < 256; c++) begin
      tab[c] = lin_entry(c);
    end
    return tab;
  endfunction

endpackage

FILE: design/rtc_const_div.sv
// ----------------------------------------------------------------------------
// rtc_const_div: pipelined floor division by a constant
// Reciprocal multiply in two partial products, then one remainder correction.
// ----------------------------------------------------------------------------
module rtc_const_div #(
  parameter int NUM_W   = rtc_pkg::XyzNumW,
  parameter int DIVISOR = rtc_pkg::WhiteYDiv,
  parameter int QUO_W   = rtc_pkg::LinW
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int K     = NUM_W + 1;
  localparam int DivW  = $clog2(DIVISOR + 1);
  localparam int MulW  = K - DivW + 2;
  localparam int LoW   = NUM_W / 2;
  localparam int HiW   = NUM_W - LoW;
  localparam int FullW = NUM_W + MulW;
  localparam int PW    = QUO_W + DivW;
  localparam int RW    = (PW > NUM_W) ? PW : NUM_W;
  localparam logic [MulW-1:0] Mul = MulW'(((K + 1)'(1'b1) << K) / DIVISOR);

  logic [HiW+MulW-1:0] hi_q;
  logic [LoW+MulW-1:0] lo_q;
  logic [NUM_W-1:0]    n1_q, n2_q, n3_q;
  logic [QUO_W-1:0]    qe2_q, qe3_q, quo_q;
  logic [PW-1:0]       pr_q;
  logic [FullW-1:0]    full;
  logic [RW-1:0]       rem;

  assign full = (FullW'(hi_q) << LoW) + FullW'(lo_q);
  assign rem  = RW'(n3_q) - RW'(pr_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q  <= (HiW + MulW)'(num_i[NUM_W-1:LoW]) * (HiW + MulW)'(Mul);
      lo_q  <= (LoW + MulW)'(num_i[LoW-1:0]) * (LoW + MulW)'(Mul);
      n1_q  <= num_i;
      qe2_q <= QUO_W'(full >> K);
      n2_q  <= n1_q;
      pr_q  <= PW'(qe2_q) * PW'(DIVISOR);
      qe3_q <= qe2_q;
      n3_q  <= n2_q;
      quo_q <= (rem >= RW'(DIVISOR)) ? qe3_q + QUO_W'(1) : qe3_q;
    end
  end

  assign quo_o = quo_q;

endmodule

FILE: design/rtc_lab_fn.sv
// ----------------------------------------------------------------------------
// rtc_lab_fn: pipelined CIE Lab companding function on one Q24 value
// Bit-serial cube root, one result bit per stage, with a linear segment path.
// ----------------------------------------------------------------------------
module rtc_lab_fn (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [rtc_pkg::LinW-1:0] t_i,
  output logic [rtc_pkg::LinW-1:0] f_o
);

  localparam int QB      = rtc_pkg::QB;
  localparam int W       = rtc_pkg::LinW;
  localparam int SqW     = 2 * W;
  localparam int S2W     = SqW - QB;
  localparam int PW      = S2W + W;
  localparam int Steps   = rtc_pkg::CbrtSteps;
  localparam int LinDly  = Steps - 1 - rtc_pkg::DivLat;
  localparam logic [W-1:0] CbrtMin   = W'((64'd8856 << QB) / 1000000);
  localparam logic [W-1:0] LinOffset = W'((64'd16 << QB) / 116);
  localparam int LinInW  = $clog2(CbrtMin + 1);
  localparam int LinNumW = LinInW + 13;
  localparam int LinQuoW = LinNumW - 9;

  // linear segment: floor(7787 * t / 1000) + 16/116
  logic [LinInW-1:0]  t_lin;
  logic [LinNumW-1:0] lin_num_q;
  logic [LinQuoW-1:0] lin_quo;
  logic [LinQuoW-1:0] dly_q [LinDly];

  assign t_lin = (t_i > CbrtMin) ? '0 : t_i[LinInW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_num_q <= LinNumW'(t_lin) * LinNumW'(7787);
      dly_q[0]  <= lin_quo;
      for (int n = 1; n < LinDly; n++) begin
        dly_q[n] <= dly_q[n-1];
      end
    end
  end

  rtc_const_div #(
    .NUM_W  (LinNumW),
    .DIVISOR(1000),
    .QUO_W  (LinQuoW)
  ) u_div (
    .clk_i(clk_i),
    .en_i (en_i),
    .num_i(lin_num_q),
    .quo_o(lin_quo)
  );

  // cube root: r and r^2 kept exact, next candidate square precomputed
  logic [W-1:0]   r_q  [Steps];
  logic [W-1:0]   t_q  [Steps];
  logic [SqW-1:0] r2_q [Steps-1];
  logic [SqW-1:0] c2_q [Steps-1];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam int K = Steps - 1 - i;
    logic [W-1:0]   r_prev, t_prev, cand;
    logic [SqW-1:0] r2_prev, c2_prev;
    logic [S2W-1:0] s2;
    logic [PW-1:0]  prod;
    logic           acc;

    if (i == 0) begin : g_first
      assign r_prev  = '0;
      assign r2_prev = '0;
      assign c2_prev = SqW'(1) << (2 * K);
      assign t_prev  = t_i;
    end else begin : g_next
      assign r_prev  = r_q[i-1];
      assign r2_prev = r2_q[i-1];
      assign c2_prev = c2_q[i-1];
      assign t_prev  = t_q[i-1];
    end

    assign cand = r_prev | (W'(1) << K);
    assign s2   = c2_prev[SqW-1:QB];
    assign prod = PW'(s2) * PW'(cand);
    assign acc  = (prod >> QB) <= PW'(t_prev);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i] <= acc ? cand : r_prev;
        t_q[i] <= t_prev;
      end
    end

    if (K > 0) begin : g_sq
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r2_q[i] <= acc ? c2_prev : r2_prev;
          c2_q[i] <= acc ? c2_prev + (SqW'(cand) << K) + (SqW'(1) << (2 * K - 2))
                         : r2_prev + (SqW'(r_prev) << K) + (SqW'(1) << (2 * K - 2));
        end
      end
    end
  end

  logic [W-1:0] f_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= (t_q[Steps-1] > CbrtMin) ? r_q[Steps-1] : W'(dly_q[LinDly-1]) + LinOffset;
    end
  end

  assign f_o = f_q;

endmodule

FILE: design/rgb_to_cielab_pixel_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_cielab_pixel_unit: 8-bit sRGB pixel to CIE L*a*b* (D65, 2 degree)
// One item per cycle while in_stall_o is low.
// Depth is set by the 25-stage cube root in each Lab function unit.
// An output skid register takes one item while a result waits; the input
// stalls only while that register is full.
// Reset clears valid bits and the skid flag; datapath registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_cielab_pixel_unit #(
  parameter int FRAC_BITS = rtc_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [14:0]        lightness_o,
  output logic signed [15:0] green_red_axis_o,
  output logic signed [15:0] blue_yellow_axis_o
);

  localparam int W       = rtc_pkg::LinW;
  localparam int NumW    = rtc_pkg::XyzNumW;
  localparam int CoreLat = 3 + rtc_pkg::DivLat + rtc_pkg::LabLat + 2;
  localparam int LW      = W + 9;
  localparam int AW      = W + 11;
  localparam int RndSh   = rtc_pkg::QB - FRAC_BITS;
  localparam int LMaxFull = 100 << FRAC_BITS;
  localparam int LMax    = (LMaxFull > 32767) ? 32767 : LMaxFull;
  localparam logic signed [LW-1:0] LOff  = LW'(16) <<< rtc_pkg::QB;
  localparam logic signed [LW-1:0] LHalf = LW'(1) <<< (RndSh - 1);
  localparam logic signed [AW-1:0] AHalf = AW'(1) <<< (RndSh - 1);
  localparam rtc_pkg::lin_tab_t LinTab = rtc_pkg::lin_table();
  // matrix rows with the white point scale folded in (X and Z times 10)
  localparam int unsigned Coef [3][3] = '{'{41240, 35760, 18050},
                                          '{2126, 7152, 722},
                                          '{1930, 11920, 95050}};
  localparam int unsigned WhiteDiv [3] = '{95047, rtc_pkg::WhiteYDiv, 108883};

  logic               adv;
  logic [CoreLat-1:0] v_q;
  logic               skid_v_q, out_v_q, take;

  logic [W-1:0]    lin_q  [3];
  logic [NumW-1:0] prod_q [3][3];
  logic [NumW-1:0] sum_q  [3];
  logic [W-1:0]    xyz    [3];
  logic [W-1:0]    f      [3];

  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[CoreLat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lin_q[0] <= LinTab[red_i];
      lin_q[1] <= LinTab[green_i];
      lin_q[2] <= LinTab[blue_i];
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[j][k] <= NumW'(lin_q[k]) * NumW'(Coef[j][k]);
        end
        sum_q[j] <= prod_q[j][0] + prod_q[j][1] + prod_q[j][2];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_chan
    rtc_const_div #(
      .NUM_W  (NumW),
      .DIVISOR(int'(WhiteDiv[j])),
      .QUO_W  (W)
    ) u_div (
      .clk_i(clk_i),
      .en_i (adv),
      .num_i(sum_q[j]),
      .quo_o(xyz[j])
    );

    rtc_lab_fn u_lab (
      .clk_i(clk_i),
      .en_i (adv),
      .t_i  (xyz[j]),
      .f_o  (f[j])
    );
  end

  // L = 116 fy - 16, a = 500 (fx - fy), b = 200 (fy - fz)
  logic signed [W:0]    dxy, dyz;
  logic signed [LW-1:0] l_q, l_rnd;
  logic signed [AW-1:0] a_q, b_q, a_rnd, b_rnd;
  logic [14:0]          l_d, l_c_q;
  logic signed [15:0]   a_d, b_d, a_c_q, b_c_q;

  assign dxy = $signed({1'b0, f[0]}) - $signed({1'b0, f[1]});
  assign dyz = $signed({1'b0, f[1]}) - $signed({1'b0, f[2]});

  assign l_rnd = (l_q + LHalf) >>> RndSh;
  assign a_rnd = (a_q + AHalf) >>> RndSh;
  assign b_rnd = (b_q + AHalf) >>> RndSh;

  always_comb begin
    if (l_rnd < 0) begin
      l_d = '0;
    end else if (l_rnd > LW'(LMax)) begin
      l_d = 15'(LMax);
    end else begin
      l_d = l_rnd[14:0];
    end
    if (a_rnd < AW'(-32768)) begin
      a_d = 16'sh8000;
    end else if (a_rnd > AW'(32767)) begin
      a_d = 16'sh7fff;
    end else begin
      a_d = a_rnd[15:0];
    end
    if (b_rnd < AW'(-32768)) begin
      b_d = 16'sh8000;
    end else if (b_rnd > AW'(32767)) begin
      b_d = 16'sh7fff;
    end else begin
      b_d = b_rnd[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_q   <= $signed({9'd0, f[1]}) * LW'(116) - LOff;
      a_q   <= AW'(dxy) * AW'(500);
      b_q   <= AW'(dyz) * AW'(200);
      l_c_q <= l_d;
      a_c_q <= a_d;
      b_c_q <= b_d;
    end
  end

  // output register plus skid
  logic [14:0]        out_l_q, skid_l_q;
  logic signed [15:0] out_a_q, out_b_q, skid_a_q, skid_b_q;

  assign take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (v_q[CoreLat-1]) begin
      if (out_v_q && !take) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_l_q <= skid_l_q;
        out_a_q <= skid_a_q;
        out_b_q <= skid_b_q;
      end
    end else if (v_q[CoreLat-1]) begin
      if (out_v_q && !take) begin
        skid_l_q <= l_c_q;
        skid_a_q <= a_c_q;
        skid_b_q <= b_c_q;
      end else begin
        out_l_q <= l_c_q;
        out_a_q <= a_c_q;
        out_b_q <= b_c_q;
      end
    end
  end

  assign out_valid_o        = out_v_q;
  assign lightness_o        = out_l_q;
  assign green_red_axis_o   = out_a_q;
  assign blue_yellow_axis_o = out_b_q;

endmodule

FILE: design/rtc_checker.sv
// ----------------------------------------------------------------------------
// rtc_checker: port-level checks for the sRGB to L*a*b* pixel unit
// Output handshake, skid behavior and lightness range, bound to the top level.
// ----------------------------------------------------------------------------
module rtc_checker #(
  parameter int FRAC_BITS = rtc_pkg::FracBitsDef
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [7:0]         red_i,
  input logic [7:0]         green_i,
  input logic [7:0]         blue_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [14:0]        lightness_o,
  input logic signed [15:0] green_red_axis_o,
  input logic signed [15:0] blue_yellow_axis_o
);

  localparam int LMaxFull = 100 << FRAC_BITS;
  localparam int LMax     = (LMaxFull > 32767) ? 32767 : LMaxFull;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(lightness_o) && $stable(green_red_axis_o)
                                   && $stable(blue_yellow_axis_o))
    else $error("stalled result item changed");

  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output backpressure");

  a_l_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(lightness_o) <= 32'(LMax))
    else $error("lightness out of range");

endmodule

bind rgb_to_cielab_pixel_unit rtc_checker #(.FRAC_BITS(FRAC_BITS)) u_rtc_checker (.*);
